// ===== hw/rtl/wft_pkg.sv =====
package wft_pkg;

  localparam int VALUE_W  = 10;
  localparam int OUT_W    = 11;
  localparam int STATUS_W = 2;

  localparam int DEF_VALUE_RANGE = 1024;
  localparam int DEF_WINDOW_MAX  = 1024;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_ABSENT = 2'd1;
  localparam status_t ST_FULL   = 2'd2;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

endpackage

// ===== hw/rtl/wft_in_if.sv =====
interface wft_in_if import wft_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== hw/rtl/wft_out_if.sv =====
interface wft_out_if import wft_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] mode_count;
  logic [OUT_W-1:0] window_size;
  status_t          status;

  modport source (output valid, output mode_count, output window_size, output status,
                  input ready);
  modport sink   (input valid, input mode_count, input window_size, input status,
                  output ready);
endinterface

// ===== hw/rtl/window_mode_frequency_tracker_unit.sv =====
// channel  | port   | payload
// ---------+--------+------------------------------------------
// input    | in_ch  | op (1b: add/remove), value (10b)
// result   | out_ch | mode_count (11b), window_size (11b), status (2b)
//
// One item at a time. An applied add or remove takes the count read-modify-write,
// hist[c] and hist[c+-1] read-modify-writes, then the result register before the
// next accept. A flagged item skips the histogram and goes from the count read to
// the result register. The single read port of each RAM and the dependent reads set
// this order. A range below 1024 that is not a power of two adds a fold step first.
// After reset both RAMs are swept to zero over max(VALUE_RANGE, WINDOW_MAX+1)
// addresses (1025 by default), with no item taken. A stalled result holds the item
// in its last state, with input ready low, until the output register frees.
module window_mode_frequency_tracker_unit import wft_pkg::*; #(
  parameter int VALUE_RANGE = DEF_VALUE_RANGE,
  parameter int WINDOW_MAX  = DEF_WINDOW_MAX
) (
  input  logic       clk,
  input  logic       rst_n,
  wft_in_if.sink     in_ch,
  wft_out_if.source  out_ch
);

  localparam int VW        = $clog2(VALUE_RANGE);
  localparam int CW        = $clog2(WINDOW_MAX + 1);
  localparam int HW        = $clog2(VALUE_RANGE + 1);
  localparam int HDEPTH    = WINDOW_MAX + 1;
  localparam int CLR_DEPTH = (VALUE_RANGE > HDEPTH) ? VALUE_RANGE : HDEPTH;
  localparam int CLRW      = $clog2(CLR_DEPTH + 1);
  localparam bit FOLD_NEEDED = (VALUE_RANGE < (1 << VALUE_W)) &&
                               ((VALUE_RANGE & (VALUE_RANGE - 1)) != 0);
  // reciprocal of the range, exact for every value below 2**VALUE_W
  localparam int     FOLD_S      = VALUE_W + $clog2(VALUE_RANGE);
  localparam int     FOLD_MW     = VALUE_W + 2;
  localparam int     FOLD_PW     = 2 * VALUE_W + 2;
  localparam longint FOLD_M_FULL = ((longint'(1) << FOLD_S) + VALUE_RANGE - 1) /
                                   VALUE_RANGE;
  localparam logic [FOLD_MW-1:0] FOLD_M = FOLD_MW'(FOLD_M_FULL);
  localparam logic [VALUE_W-1:0] FOLD_R = VALUE_W'(VALUE_RANGE);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_FOLD = 3'd2;
  localparam logic [2:0] S_CNT  = 3'd3;
  localparam logic [2:0] S_H1   = 3'd4;
  localparam logic [2:0] S_H2   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [CLRW-1:0]    clr_r, clr_nxt;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic               op_r, op_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      nbr_r, nbr_nxt;
  logic [CW-1:0]      mode_r, mode_nxt;
  logic [CW-1:0]      total_r, total_nxt;
  status_t            status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_mode_r, out_mode_nxt;
  logic [OUT_W-1:0]   out_size_r, out_size_nxt;
  status_t            out_status_r, out_status_nxt;

  logic          cnt_we;
  logic [VW-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0] cnt_wdata, cnt_rdata;
  logic          hist_we;
  logic [CW-1:0] hist_waddr, hist_raddr;
  logic [HW-1:0] hist_wdata, hist_rdata;

  logic          in_fire, out_free;
  logic [VW-1:0] slot;
  logic [FOLD_PW-1:0] fold_prod;
  logic [VALUE_W-1:0] fold_q;
  logic [VALUE_W-1:0] fold_rem;

  wft_ram #(.WIDTH(CW), .DEPTH(VALUE_RANGE)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  wft_ram #(.WIDTH(HW), .DEPTH(HDEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.mode_count  = out_mode_r;
  assign out_ch.window_size = out_size_r;
  assign out_ch.status      = out_status_r;

  // truncation masks a power-of-two range; otherwise rem_r is already folded
  assign slot = VW'(rem_r);

  // value mod VALUE_RANGE: quotient by reciprocal multiply, then one subtract
  always_comb begin
    fold_prod = FOLD_PW'(rem_r) * FOLD_PW'(FOLD_M);
    fold_q    = VALUE_W'(fold_prod >> FOLD_S);
    fold_rem  = rem_r - fold_q * FOLD_R;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    rem_nxt        = rem_r;
    op_nxt         = op_r;
    cnt_nxt        = cnt_r;
    nbr_nxt        = nbr_r;
    mode_nxt       = mode_r;
    total_nxt      = total_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_mode_nxt   = out_mode_r;
    out_size_nxt   = out_size_r;
    out_status_nxt = out_status_r;

    cnt_we     = 1'b0;
    cnt_waddr  = slot;
    cnt_wdata  = '0;
    cnt_raddr  = FOLD_NEEDED ? VW'(fold_rem) : VW'(in_ch.value);
    hist_we    = 1'b0;
    hist_waddr = cnt_r;
    hist_wdata = '0;
    hist_raddr = cnt_rdata;

    case (state_r)
      S_CLR: begin
        cnt_we     = (clr_r < CLRW'(VALUE_RANGE));
        cnt_waddr  = clr_r[VW-1:0];
        hist_we    = (clr_r < CLRW'(HDEPTH));
        hist_waddr = clr_r[CW-1:0];
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == CLRW'(CLR_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_raddr = VW'(in_ch.value);
        if (in_fire) begin
          op_nxt    = in_ch.op;
          rem_nxt   = in_ch.value;
          state_nxt = FOLD_NEEDED ? S_FOLD : S_CNT;
        end
      end
      S_FOLD: begin
        // count read goes out at the folded address this cycle
        rem_nxt   = fold_rem;
        state_nxt = S_CNT;
      end
      S_CNT: begin
        cnt_nxt    = cnt_rdata;
        hist_raddr = cnt_rdata;
        if (op_r == OP_REMOVE && cnt_rdata == '0) begin
          status_nxt = ST_ABSENT;
          state_nxt  = S_OUT;
        end else if (op_r == OP_ADD && total_r >= CW'(WINDOW_MAX)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_OUT;
        end else begin
          status_nxt = ST_OK;
          nbr_nxt    = (op_r == OP_REMOVE) ? cnt_rdata - 1'b1 : cnt_rdata + 1'b1;
          total_nxt  = (op_r == OP_REMOVE) ? total_r - 1'b1 : total_r + 1'b1;
          cnt_we     = 1'b1;
          cnt_wdata  = nbr_nxt;
          state_nxt  = S_H1;
        end
      end
      S_H1: begin
        // hist_rdata is hist[cnt_r]; the max moves by at most one step
        hist_we    = (cnt_r != '0);
        hist_waddr = cnt_r;
        hist_wdata = hist_rdata - 1'b1;
        hist_raddr = nbr_r;
        if (op_r == OP_ADD) begin
          if (nbr_r > mode_r) begin
            mode_nxt = nbr_r;
          end
        end else if (cnt_r == mode_r && hist_rdata == HW'(1)) begin
          mode_nxt = nbr_r;
        end
        state_nxt = S_H2;
      end
      S_H2: begin
        hist_we    = (nbr_r != '0);
        hist_waddr = nbr_r;
        hist_wdata = hist_rdata + 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_mode_nxt   = OUT_W'(mode_r);
          out_size_nxt   = OUT_W'(total_r);
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      mode_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      mode_r      <= mode_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    op_r         <= op_nxt;
    cnt_r        <= cnt_nxt;
    nbr_r        <= nbr_nxt;
    status_r     <= status_nxt;
    out_mode_r   <= out_mode_nxt;
    out_size_r   <= out_size_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ===== hw/rtl/wft_ram.sv =====
module wft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/window_mode_frequency_tracker_unit_test.sv =====
module window_mode_frequency_tracker_unit_test import wft_pkg::*; ();

  localparam int VAL_RANGE = DEF_VALUE_RANGE;
  localparam int WIN_MAX   = DEF_WINDOW_MAX;
  localparam int POOL_N    = 8;

  typedef struct packed {
    logic [OUT_W-1:0] mode_count;
    logic [OUT_W-1:0] window_size;
    status_t          status;
  } tally_t;

  logic clk;
  logic rst_n;

  wft_in_if  in_ch ();
  wft_out_if out_ch ();

  window_mode_frequency_tracker_unit #(
    .VALUE_RANGE(VAL_RANGE),
    .WINDOW_MAX (WIN_MAX)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow of the window: per-value counts, per-count histogram, mode, size
  logic [OUT_W-1:0] occurrences [VAL_RANGE]   = '{default: '0};
  logic [OUT_W-1:0] holders     [WIN_MAX + 1] = '{default: '0};
  logic [OUT_W-1:0] top_count    = '0;
  logic [OUT_W-1:0] window_total = '0;

  tally_t           pending_tallies [$];
  logic [VALUE_W-1:0] pool [POOL_N];
  int               err_count     = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_left     = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic tally_t track_item(logic op, logic [VALUE_W-1:0] value);
    int     slot;
    int     c;
    tally_t t;
    slot     = int'(value) % VAL_RANGE;
    c        = int'(occurrences[slot]);
    t.status = ST_OK;
    if (op == OP_REMOVE) begin
      if (c == 0) begin
        t.status = ST_ABSENT;
      end else begin
        holders[c] = holders[c] - 1'b1;
        c--;
        if (c > 0) holders[c] = holders[c] + 1'b1;
        occurrences[slot] = c[OUT_W-1:0];
        window_total      = window_total - 1'b1;
      end
    end else if (int'(window_total) >= WIN_MAX) begin
      t.status = ST_FULL;
    end else begin
      if (c > 0) holders[c] = holders[c] - 1'b1;
      c++;
      holders[c]        = holders[c] + 1'b1;
      occurrences[slot] = c[OUT_W-1:0];
      window_total      = window_total + 1'b1;
    end
    if (t.status == ST_OK) begin
      // mode climbs at most one step, falls until a populated count is found
      if (int'(top_count) < WIN_MAX && holders[int'(top_count) + 1] != 0)
        top_count = top_count + 1'b1;
      while (top_count != 0 && holders[top_count] == 0)
        top_count = top_count - 1'b1;
    end
    t.mode_count  = top_count;
    t.window_size = window_total;
    return t;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 75) return pool[$urandom_range(0, POOL_N - 1)];
    return VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
  endfunction

  task automatic send_item(logic op, logic [VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_tallies.insert(pending_tallies.size(), track_item(op, value));
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_N; i++) pool[i] = VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
  endtask

  task automatic test_edge_items();
    send_item(OP_REMOVE, 10'd0);       // remove from empty window
    send_item(OP_ADD,    10'd0);
    send_item(OP_ADD,    10'h3FF);
    send_item(OP_ADD,    10'h3FF);     // mode goes to 2
    send_item(OP_ADD,    10'h2AA);
    send_item(OP_ADD,    10'h155);
    send_item(OP_REMOVE, 10'h3FF);     // mode back to 1
    send_item(OP_REMOVE, 10'h3FF);
    send_item(OP_REMOVE, 10'h3FF);     // no longer present
    send_item(OP_REMOVE, 10'h2AA);
    send_item(OP_REMOVE, 10'h155);
    send_item(OP_REMOVE, 10'd0);       // window empty, mode 0
    send_item(OP_ADD,    10'h155);
    send_item(OP_ADD,    10'h155);
    send_item(OP_ADD,    10'h155);
    send_item(OP_REMOVE, 10'h155);
    send_item(OP_ADD,    10'h2AA);
    send_item(OP_REMOVE, 10'h155);
    send_item(OP_REMOVE, 10'h2AA);
    send_item(OP_REMOVE, 10'h155);
  endtask

  task automatic test_mixed_traffic(int n_items);
    logic op;
    refill_pool();
    for (int i = 0; i < n_items; i++) begin
      op = ($urandom_range(0, 99) < 55) ? OP_ADD : OP_REMOVE;
      send_item(op, pick_value());
    end
  endtask

  task automatic test_stalled_output();
    refill_pool();
    hold_left = 400;
    for (int i = 0; i < 30; i++) send_item(OP_ADD, pick_value());
  endtask

  task automatic test_drain();
    logic [VALUE_W-1:0] v;
    int                 probe;
    refill_pool();
    while (window_total != 0) begin
      v = pick_value();
      if (occurrences[v] == 0 && $urandom_range(0, 99) < 90) begin
        // mostly walk to the next value still in the window
        for (probe = 0; probe < VAL_RANGE && occurrences[v] == 0; probe++) v = v + 1'b1;
      end
      send_item(OP_REMOVE, v);
    end
  endtask

  initial begin : drive_result_ready
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_tallies
    tally_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_tallies.size() == 0) begin
        $display("%0t: unexpected item mode_count %0d window_size %0d status %0d", $time,
                 out_ch.mode_count, out_ch.window_size, out_ch.status);
        err_count++;
      end else begin
        want = pending_tallies.pop_front();
        if (out_ch.mode_count !== want.mode_count) begin
          $display("%0t: mode_count expected %0d actual %0d", $time, want.mode_count,
                   out_ch.mode_count);
          err_count++;
        end
        if (out_ch.window_size !== want.window_size) begin
          $display("%0t: window_size expected %0d actual %0d", $time, want.window_size,
                   out_ch.window_size);
          err_count++;
        end
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("window_mode_frequency_tracker_unit_test: errors");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op    <= OP_ADD;
    in_ch.value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 66;
    test_edge_items();
    test_mixed_traffic(180);

    send_idle_pct = 66;
    recv_idle_pct = 20;
    test_mixed_traffic(160);
    test_stalled_output();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_mixed_traffic(160);
    test_drain();

    in_ch.valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("window_mode_frequency_tracker_unit_test: clean");
    end else begin
      $display("window_mode_frequency_tracker_unit_test: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wft_pkg.sv
hw/rtl/wft_in_if.sv
hw/rtl/wft_out_if.sv
hw/rtl/wft_ram.sv
hw/rtl/window_mode_frequency_tracker_unit.sv
verif/window_mode_frequency_tracker_unit_test.sv
